@@ src/dual_frame_command_deframer_defines.svh @@
// Assertion macros for the dual frame command deframer.
`ifndef DUAL_FRAME_COMMAND_DEFRAMER_DEFINES_SVH
`define DUAL_FRAME_COMMAND_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DFCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DFCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

@@ src/dfcd_pkg.sv @@
// Package with the types and constants of the dual frame command deframer.
package dfcd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_BIN  = 2'd1;
  localparam logic [1:0] KIND_TEXT = 2'd2;

  // Framing characters
  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_M    = 8'h4D;
  localparam logic [7:0] CHAR_LM   = 8'h6D;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_DEL  = 8'h7F;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  // Frame lengths and text-frame field positions
  localparam logic [3:0] BIN_LEN     = 4'd5;
  localparam logic [3:0] TEXT_LEN    = 4'd11;
  localparam logic [3:0] TPOS_CMD    = 4'd1;
  localparam logic [3:0] TPOS_SPACE  = 4'd2;
  localparam logic [3:0] TPOS_DIGEND = 4'd8;
  localparam logic [3:0] TPOS_CR     = 4'd9;

  // Result queue; depth must be a power of two and at least 2
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  typedef logic [QPTR_W-1:0] qptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cmd_code;
    logic [27:0] argument;
    logic [7:0]  echo_byte;
    logic        last;
  } res_t;

endpackage

@@ src/dual_frame_command_deframer.sv @@
// Dual frame command deframer: frame recognizer and result queue.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data_byte) takes one received byte
//   per item. Binary frames (head byte with bit 7 set plus four 7-bit bytes)
//   and text frames ("S", M or m, space, six digits, CR, 0x7F) are recognized.
//   Result channel (out_valid / out_stall / out_*) carries one result per item:
//   a head byte echo, a binary command or a text command. A byte causes zero,
//   one or two results; out_last marks the final one of a byte.
//   A result is written into the queue when its byte is taken and is shown on
//   the output once the older results have left. Throughput: one byte per cycle
//   while in_stall is low. Frame state is updated by combinational compare and
//   shift logic; results wait in a four-entry queue. in_stall rises when the
//   queue has fewer than two free entries, so a stalled receiver backs up into the input; nothing is dropped.
//   Reset (synchronous, rst_n low) returns to idle and empties the queue.
module dual_frame_command_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_cmd_code,
  output logic [27:0] out_argument,
  output logic [7:0]  out_echo_byte,
  output logic        out_last
);

`include "dual_frame_command_deframer_defines.svh"

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BIN  = 2'd1,
    MODE_TEXT = 2'd2
  } mode_t;

  // Frame state
  mode_t       mode_r, mode_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  head_r, head_nxt;
  logic [27:0] acc_r, acc_nxt;

  // Result queue
  dfcd_pkg::res_t fifo_r [dfcd_pkg::QDEPTH];
  dfcd_pkg::qptr_t wr_ptr_r, wr_ptr_nxt;
  dfcd_pkg::qptr_t rd_ptr_r, rd_ptr_nxt;
  dfcd_pkg::cnt_t  count_r, count_nxt;

  dfcd_pkg::res_t res0, res1;
  logic [1:0]  n_res;
  logic        redo;
  logic        bad;
  logic [3:0]  pos_inc;
  logic [7:0]  dig;
  logic [7:0]  b;
  logic        in_fire;
  logic        out_fire;

  function automatic dfcd_pkg::res_t make_echo(input logic [7:0] hb, input logic lst);
    dfcd_pkg::res_t r;
    r           = '0;
    r.kind      = dfcd_pkg::KIND_ECHO;
    r.echo_byte = hb;
    r.last      = lst;
    return r;
  endfunction

  assign b        = in_data_byte;
  assign in_stall = (count_r > dfcd_pkg::cnt_t'(dfcd_pkg::QDEPTH - 2));
  assign in_fire  = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_fire = out_valid && !out_stall;

  // Next frame state and the results caused by the current byte.
  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    head_nxt = head_r;
    acc_nxt  = acc_r;
    res0     = '0;
    res1     = '0;
    n_res    = 2'd0;
    redo     = 1'b0;
    bad      = 1'b0;
    pos_inc  = pos_r + 4'd1;
    dig      = b - dfcd_pkg::CHAR_ZERO;

    unique case (mode_r)
      MODE_BIN: begin
        if (!b[7] && pos_r >= 4'd1 && pos_r < dfcd_pkg::BIN_LEN) begin
          acc_nxt = {acc_r[20:0], b[6:0]};
          pos_nxt = pos_inc;
          if (pos_inc == dfcd_pkg::BIN_LEN) begin
            res0.kind     = dfcd_pkg::KIND_BIN;
            res0.cmd_code = {4'h0, head_r[3:0]};
            res0.argument = acc_nxt;
            res0.last     = 1'b1;
            n_res         = 2'd1;
            mode_nxt      = MODE_IDLE;
            pos_nxt       = 4'd0;
          end
        end else if (b[7]) begin
          // head interrupts a binary frame: echo now, then restart as a head
          res0  = make_echo(b, 1'b0);
          n_res = 2'd1;
          redo  = 1'b1;
        end else begin
          redo = 1'b1;
        end
      end
      MODE_TEXT: begin
        priority if (pos_r < dfcd_pkg::TPOS_CMD || pos_r >= dfcd_pkg::TEXT_LEN) begin
          bad = 1'b1;
        end else if (pos_r == dfcd_pkg::TPOS_CMD) begin
          if (b != dfcd_pkg::CHAR_M && b != dfcd_pkg::CHAR_LM) begin
            bad = 1'b1;
          end else begin
            head_nxt = b;
          end
        end else if (pos_r == dfcd_pkg::TPOS_SPACE) begin
          bad = (b != dfcd_pkg::CHAR_SP);
        end else if (pos_r <= dfcd_pkg::TPOS_DIGEND) begin
          acc_nxt = {acc_r[23:0], dig[3:0]};
        end else if (pos_r == dfcd_pkg::TPOS_CR) begin
          bad = (b != dfcd_pkg::CHAR_CR);
        end else begin
          bad = (b != dfcd_pkg::CHAR_DEL);
        end

        if (bad) begin
          redo = 1'b1;
        end else begin
          pos_nxt = pos_inc;
          if (pos_inc == dfcd_pkg::TEXT_LEN) begin
            res0.kind     = dfcd_pkg::KIND_TEXT;
            res0.cmd_code = head_nxt;
            res0.argument = {4'h0, acc_nxt[23:0]};
            res0.last     = 1'b1;
            n_res         = 2'd1;
            mode_nxt      = MODE_IDLE;
            pos_nxt       = 4'd0;
          end
        end
      end
      default: begin
        redo = 1'b1;
      end
    endcase

    // Examine the byte from idle: start a binary or text frame, or drop it.
    if (redo) begin
      mode_nxt = MODE_IDLE;
      pos_nxt  = 4'd0;
      if (b[7]) begin
        mode_nxt = MODE_BIN;
        pos_nxt  = 4'd1;
        head_nxt = b;
        acc_nxt  = '0;
        if (n_res == 2'd0) begin
          res0 = make_echo(b, 1'b1);
        end else begin
          res1 = make_echo(b, 1'b1);
        end
        n_res = n_res + 2'd1;
      end else if (b == dfcd_pkg::CHAR_S) begin
        mode_nxt = MODE_TEXT;
        pos_nxt  = 4'd1;
        head_nxt = '0;
        acc_nxt  = '0;
      end
    end
  end

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (in_fire) begin
      wr_ptr_nxt = wr_ptr_r + dfcd_pkg::QPTR_W'(n_res);
      count_nxt  = count_nxt + dfcd_pkg::CNT_W'(n_res);
    end
    if (out_fire) begin
      rd_ptr_nxt = rd_ptr_r + dfcd_pkg::qptr_t'(1);
      count_nxt  = count_nxt - dfcd_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= 4'd0;
      head_r   <= 8'd0;
      acc_r    <= 28'd0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_fire) begin
        mode_r <= mode_nxt;
        pos_r  <= pos_nxt;
        head_r <= head_nxt;
        acc_r  <= acc_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage; no reset needed, the fill count guards it.
  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (in_fire && n_res == 2'd2) begin
      fifo_r[wr_ptr_r + dfcd_pkg::qptr_t'(1)] <= res1;
    end
  end

  assign out_kind      = fifo_r[rd_ptr_r].kind;
  assign out_cmd_code  = fifo_r[rd_ptr_r].cmd_code;
  assign out_argument  = fifo_r[rd_ptr_r].argument;
  assign out_echo_byte = fifo_r[rd_ptr_r].echo_byte;
  assign out_last      = fifo_r[rd_ptr_r].last;

  // Checks
  `DFCD_ASSERT_NOW(a_count_bound, 1'b1, count_r <= dfcd_pkg::cnt_t'(dfcd_pkg::QDEPTH))
  `DFCD_ASSERT_NOW(a_idle_pos, mode_r == MODE_IDLE, pos_r == 4'd0)
  `DFCD_ASSERT_NOW(a_bin_pos, mode_r == MODE_BIN,
                   pos_r >= 4'd1 && pos_r < dfcd_pkg::BIN_LEN)
  `DFCD_ASSERT_NOW(a_text_pos, mode_r == MODE_TEXT,
                   pos_r >= 4'd1 && pos_r < dfcd_pkg::TEXT_LEN)
  `DFCD_ASSERT_NOW(a_nonlast_echo, out_valid && !out_last,
                   out_kind == dfcd_pkg::KIND_ECHO)
  `DFCD_ASSERT_NEXT(a_double_push,
                    in_fire && b[7] && mode_r == MODE_BIN && !out_fire,
                    count_r == $past(count_r) + dfcd_pkg::cnt_t'(2))

endmodule

@@ tb/tb_dual_frame_command_deframer.sv @@
`timescale 1ns / 1ps
// Testbench that checks the dual frame command deframer byte by byte against a built-in predictor.
module tb_dual_frame_command_deframer;

  // Cycles with no item moving on either channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned MAX_SHOWN   = 10;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BIN  = 2'd1,
    MODE_TEXT = 2'd2
  } frame_mode_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_cmd_code;
  logic [27:0] out_argument;
  logic [7:0]  out_echo_byte;
  logic        out_last;

  // Predictor copy of the frame state.
  frame_mode_t mode_q = MODE_IDLE;
  logic [3:0]  pos_q  = 4'd0;
  logic [7:0]  head_q = 8'h00;
  logic [27:0] acc_q  = 28'h0;

  dfcd_pkg::res_t pending_results[$];   // decoded results not yet seen on the output
  logic [7:0]     frame_bytes[$];       // bytes of the burst about to be sent
  dfcd_pkg::res_t want_result;
  int unsigned failures = 0;
  int unsigned busy_bytes = 0;       // accepted bytes that were not simply ignored
  int unsigned quiet_cycles = 0;
  bit          no_gaps = 1'b0;       // suppress random idling on both channels

  dual_frame_command_deframer dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_cmd_code (out_cmd_code),
    .out_argument (out_argument),
    .out_echo_byte(out_echo_byte),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function void note_failure(input string what);
    failures++;
    if (failures <= MAX_SHOWN) $display("%s", what);
  endfunction

  task automatic push_result(input logic [1:0] kind, input logic [7:0] cmd,
                             input logic [27:0] arg, input logic [7:0] echo,
                             input logic last);
    dfcd_pkg::res_t r;
    r.kind      = kind;
    r.cmd_code  = cmd;
    r.argument  = arg;
    r.echo_byte = echo;
    r.last      = last;
    pending_results.push_back(r);
  endtask

  // Drop any frame in progress and look at the byte as if idle: a head byte
  // opens a binary frame and is echoed, 'S' opens a text frame, else nothing.
  task automatic restart_from_idle(input logic [7:0] b, output bit taken);
    mode_q = MODE_IDLE;
    pos_q  = 4'd0;
    taken  = 1'b1;
    if (b[7]) begin
      mode_q = MODE_BIN;
      pos_q  = 4'd1;
      head_q = b;
      acc_q  = 28'h0;
      push_result(dfcd_pkg::KIND_ECHO, 8'h00, 28'h0, b, 1'b1);
    end else if (b == dfcd_pkg::CHAR_S) begin
      mode_q = MODE_TEXT;
      pos_q  = 4'd1;
      head_q = 8'h00;
      acc_q  = 28'h0;
    end else begin
      taken = 1'b0;
    end
  endtask

  // Advance the predicted state by one accepted byte and queue its results.
  task automatic predict_byte(input logic [7:0] b, output bit ignored);
    bit         bad;
    bit         taken;
    logic [7:0] digit;
    ignored = 1'b0;
    bad     = 1'b0;
    digit   = b - dfcd_pkg::CHAR_ZERO;
    case (mode_q)
      MODE_BIN: begin
        if (!b[7] && pos_q >= 4'd1 && pos_q < dfcd_pkg::BIN_LEN) begin
          acc_q = {acc_q[20:0], b[6:0]};
          pos_q = pos_q + 4'd1;
          if (pos_q == dfcd_pkg::BIN_LEN) begin
            push_result(dfcd_pkg::KIND_BIN, {4'h0, head_q[3:0]}, acc_q, 8'h00, 1'b1);
            mode_q = MODE_IDLE;
            pos_q  = 4'd0;
          end
        end else begin
          // A head byte inside a binary frame is echoed once for the dropped
          // frame and once more as the head of the new one.
          if (b[7]) push_result(dfcd_pkg::KIND_ECHO, 8'h00, 28'h0, b, 1'b0);
          restart_from_idle(b, taken);
        end
      end
      MODE_TEXT: begin
        if (pos_q < dfcd_pkg::TPOS_CMD || pos_q >= dfcd_pkg::TEXT_LEN) begin
          bad = 1'b1;
        end else if (pos_q == dfcd_pkg::TPOS_CMD) begin
          if (b != dfcd_pkg::CHAR_M && b != dfcd_pkg::CHAR_LM) bad = 1'b1;
          else head_q = b;
        end else if (pos_q == dfcd_pkg::TPOS_SPACE) begin
          bad = (b != dfcd_pkg::CHAR_SP);
        end else if (pos_q <= dfcd_pkg::TPOS_DIGEND) begin
          // Digits are not checked; any byte contributes its low nibble.
          acc_q = {acc_q[23:0], digit[3:0]};
        end else if (pos_q == dfcd_pkg::TPOS_CR) begin
          bad = (b != dfcd_pkg::CHAR_CR);
        end else begin
          bad = (b != dfcd_pkg::CHAR_DEL);
        end
        if (bad) begin
          restart_from_idle(b, taken);
        end else begin
          pos_q = pos_q + 4'd1;
          if (pos_q == dfcd_pkg::TEXT_LEN) begin
            push_result(dfcd_pkg::KIND_TEXT, head_q, {4'h0, acc_q[23:0]}, 8'h00, 1'b1);
            mode_q = MODE_IDLE;
            pos_q  = 4'd0;
          end
        end
      end
      default: begin
        restart_from_idle(b, taken);
        ignored = !taken;
      end
    endcase
  endtask

  // Offer one byte, hold it until accepted, then predict its results.
  task automatic send_byte(input logic [7:0] b);
    bit ignored;
    while (!no_gaps && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, ignored);
    if (!ignored) busy_bytes++;
  endtask

  task automatic send_queued_bytes();
    while (frame_bytes.size() != 0) send_byte(frame_bytes.pop_front());
  endtask

  task automatic queue_binary(input logic [7:0] head, input logic [27:0] arg);
    frame_bytes.push_back(head);
    for (int i = 3; i >= 0; i--) frame_bytes.push_back({1'b0, arg[i*7 +: 7]});
  endtask

  // Digits are six bytes, first digit in the top byte.
  task automatic queue_text(input logic [7:0] letter, input logic [47:0] digits);
    frame_bytes.push_back(dfcd_pkg::CHAR_S);
    frame_bytes.push_back(letter);
    frame_bytes.push_back(dfcd_pkg::CHAR_SP);
    for (int i = 5; i >= 0; i--) frame_bytes.push_back(digits[i*8 +: 8]);
    frame_bytes.push_back(dfcd_pkg::CHAR_CR);
    frame_bytes.push_back(dfcd_pkg::CHAR_DEL);
  endtask

  // Stop sending and hold until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Queue one random burst: mostly well-formed frames with random content,
  // the rest truncated or corrupted frames and loose noise bytes.
  task automatic queue_random_burst();
    logic [31:0] rnd;
    logic [47:0] digits;
    logic [7:0]  letter;
    logic [7:0]  spare;
    int unsigned pick;
    int unsigned slot;
    rnd  = $urandom;
    pick = $urandom_range(99);
    letter = rnd[0] ? dfcd_pkg::CHAR_M : dfcd_pkg::CHAR_LM;
    digits = 48'h0;
    for (int i = 0; i < 6; i++) begin
      rnd = $urandom;
      if (rnd[31:28] == 4'h0) digits = {digits[39:0], rnd[7:0]};
      else digits = {digits[39:0], dfcd_pkg::CHAR_ZERO + 8'(rnd[15:8] % 10)};
    end
    rnd = $urandom;
    case ($urandom_range(2))
      0:       spare = {1'b1, rnd[6:0]};
      1:       spare = dfcd_pkg::CHAR_S;
      default: spare = rnd[7:0];
    endcase
    if (pick < 35) begin
      rnd = $urandom;
      queue_binary({1'b1, rnd[30:24]}, rnd[27:0]);
    end else if (pick < 70) begin
      queue_text(letter, digits);
    end else if (pick < 88) begin
      if ($urandom_range(1) == 0) begin
        // Binary frame cut short; whatever non-head bytes follow land in its data slots.
        rnd = $urandom;
        queue_binary({1'b1, rnd[30:24]}, rnd[27:0]);
        repeat ($urandom_range(4, 1)) void'(frame_bytes.pop_back());
      end else begin
        queue_text(letter, digits);
        slot = $urandom_range(4);
        case (slot)
          0: frame_bytes[dfcd_pkg::TPOS_CMD]        = spare;
          1: frame_bytes[dfcd_pkg::TPOS_SPACE]      = spare;
          2: frame_bytes[dfcd_pkg::TPOS_CR]         = spare;
          3: frame_bytes[dfcd_pkg::TEXT_LEN - 4'd1] = spare;
          default: repeat ($urandom_range(9, 1)) void'(frame_bytes.pop_back());
        endcase
      end
    end else begin
      repeat ($urandom_range(4, 1)) begin
        rnd = $urandom;
        frame_bytes.push_back(rnd[7:0]);
      end
    end
  endtask

  // Extreme binary frame with all payload bits set, after an ignored byte.
  task automatic test_binary_frames();
    send_byte(8'h41);
    queue_binary(8'hFF, 28'hFFFFFFF);
    send_queued_bytes();
  endtask

  // A head byte cuts into an open binary frame, then the new frame completes
  // with an all-zero payload.
  task automatic test_head_interrupt();
    frame_bytes.push_back(8'h80);
    frame_bytes.push_back(8'h00);
    queue_binary(8'h8F, 28'h0);
    send_queued_bytes();
  endtask

  // A text frame whose digit slots carry some non-digit bytes, then one aborted
  // at the space slot by a byte that is ignored from idle.
  task automatic test_text_frames();
    queue_text(dfcd_pkg::CHAR_LM, {8'h39, dfcd_pkg::CHAR_ZERO, 8'h2F, 8'hFF, 8'h35, 8'h00});
    frame_bytes.push_back(dfcd_pkg::CHAR_S);
    frame_bytes.push_back(dfcd_pkg::CHAR_M);
    frame_bytes.push_back(8'h58);
    send_queued_bytes();
  endtask

  // Random bursts; every hundred counted bytes let the output drain fully.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned start;
    int unsigned last_drain;
    start      = busy_bytes;
    last_drain = busy_bytes;
    while (busy_bytes - start < count) begin
      queue_random_burst();
      send_queued_bytes();
      if (busy_bytes - last_drain >= 100) begin
        wait_drained();
        last_drain = busy_bytes;
      end
    end
  endtask

  // Full-rate stretch: no source gaps and no output stalls.
  task automatic test_back_to_back(input int unsigned count);
    no_gaps = 1'b1;
    test_random_traffic(count);
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_binary_frames();
    test_head_interrupt();
    test_text_frames();
    test_random_traffic(400);
    test_back_to_back(130);
    test_random_traffic(30);
    wait_drained();
    // Keep clocking after the drain so stray results still show up.
    repeat (4) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Compare each accepted result with the oldest prediction and drive the
  // receiver's random stalls.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: kind %0d cmd %h arg %h echo %h last %b",
                               out_kind, out_cmd_code, out_argument, out_echo_byte, out_last));
      end else begin
        want_result = pending_results.pop_front();
        if (out_kind !== want_result.kind || out_cmd_code !== want_result.cmd_code ||
            out_argument !== want_result.argument ||
            out_echo_byte !== want_result.echo_byte || out_last !== want_result.last) begin
          note_failure($sformatf(
            "mismatch: kind %0d/%0d cmd %h/%h arg %h/%h echo %h/%h last %b/%b (exp/got)",
            want_result.kind, out_kind, want_result.cmd_code, out_cmd_code,
            want_result.argument, out_argument, want_result.echo_byte, out_echo_byte,
            want_result.last, out_last));
        end
      end
    end
    out_stall <= !no_gaps && ($urandom_range(99) < 10);
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ files.f @@
+incdir+src
src/dfcd_pkg.sv
src/dual_frame_command_deframer.sv
tb/tb_dual_frame_command_deframer.sv
